// ----- src/sync_crc_packet_framer_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sync CRC packet framer
// Shared clocking and reset gating for the concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SYNC_CRC_PACKET_FRAMER_ASSERT_SVH
`define SYNC_CRC_PACKET_FRAMER_ASSERT_SVH

// same-cycle implication
`define SCPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/scpf_pkg.sv -----
// ----------------------------------------------------------------------------
// scpf_pkg
// Shared types, codes and the CRC-16/CCITT-FALSE byte update.
// ----------------------------------------------------------------------------
package scpf_pkg;

  localparam int S_DATA_W    = 32;
  localparam int S_USER_W    = 1;
  localparam int M_DATA_W    = 8;
  localparam int M_USER_W    = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

  localparam logic [7:0] SYNC_FIRST_RESET  = 8'hFF;
  localparam logic [7:0] SYNC_SECOND_RESET = 8'h8C;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  localparam logic [1:0] FAULT_NONE    = 2'd0;
  localparam logic [1:0] FAULT_STRAY   = 2'd1;
  localparam logic [1:0] FAULT_ABANDON = 2'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_DATA,
    KIND_STRAY
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        abandon;
    logic        last;
    logic [7:0]  data;
    logic [15:0] len;
  } cmd_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- src/scpf_front.sv -----
// ----------------------------------------------------------------------------
// scpf_front
// Accepts input words, tracks the open packet and classifies each word.
// ----------------------------------------------------------------------------
module scpf_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [scpf_pkg::S_DATA_W-1:0]     s_tdata,
  input  logic [scpf_pkg::S_USER_W-1:0]     s_tuser,
  input  logic                              q_full,
  output logic                              q_push,
  output scpf_pkg::cmd_t                    q_cmd
);

  logic        packet_open;
  logic [15:0] bytes_left;
  logic        is_start;
  logic [7:0]  packet_id;
  logic [15:0] payload_length;
  logic [7:0]  payload_byte;

  assign packet_id      = s_tdata[7:0];
  assign payload_length = s_tdata[23:8];
  assign payload_byte   = s_tdata[31:24];
  assign is_start       = (s_tuser[0] == scpf_pkg::OP_START);

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    q_cmd.len = payload_length;
    if (is_start) begin
      q_cmd.kind    = scpf_pkg::KIND_START;
      q_cmd.abandon = packet_open;
      q_cmd.last    = (payload_length == 16'd0);
      q_cmd.data    = packet_id;
    end else begin
      q_cmd.kind    = packet_open ? scpf_pkg::KIND_DATA : scpf_pkg::KIND_STRAY;
      q_cmd.abandon = 1'b0;
      q_cmd.last    = (bytes_left == 16'd1);
      q_cmd.data    = payload_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_open <= 1'b0;
      bytes_left  <= 16'd0;
    end else if (q_push) begin
      if (is_start) begin
        packet_open <= (payload_length != 16'd0);
        bytes_left  <= payload_length;
      end else if (packet_open) begin
        bytes_left <= bytes_left - 16'd1;
        if (bytes_left == 16'd1) begin
          packet_open <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- src/scpf_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// scpf_cmd_fifo
// Short first-word-fall-through queue of classified commands.
// ----------------------------------------------------------------------------
module scpf_cmd_fifo #(
  parameter int DEPTH = scpf_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  scpf_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output scpf_pkg::cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  scpf_pkg::cmd_t     mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- src/scpf_back.sv -----
// ----------------------------------------------------------------------------
// scpf_back
// Sequences header, payload and CRC bytes from queued commands into the
// output register; holds the sync byte registers and the running CRC.
// ----------------------------------------------------------------------------
module scpf_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [scpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scpf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              head_valid,
  input  scpf_pkg::cmd_t                    head,
  output logic                              pop,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [scpf_pkg::M_DATA_W-1:0]     m_tdata,
  output logic [scpf_pkg::M_USER_W-1:0]     m_tuser,
  output logic                              m_tlast
);

  typedef enum logic [2:0] {
    ST_FIRST,
    ST_SYNC2,
    ST_ID,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_CRC_LO,
    ST_CRC_HI
  } step_t;

  step_t       step;
  step_t       step_next;
  logic [15:0] crc;
  logic [15:0] crc_next;
  logic [7:0]  sync_first;
  logic [7:0]  sync_second;
  logic [7:0]  byte_next;
  logic [1:0]  fault_next;
  logic        valid_next;
  logic        fin;
  logic        fire;

  assign fire = head_valid && (!m_tvalid || m_tready);
  assign pop  = fire && fin;

  always_comb begin
    byte_next  = 8'd0;
    fault_next = scpf_pkg::FAULT_NONE;
    valid_next = 1'b1;
    fin        = 1'b0;
    crc_next   = crc;
    step_next  = step;
    unique case (step)
      ST_FIRST: begin
        unique case (head.kind)
          scpf_pkg::KIND_START: begin
            byte_next  = sync_first;
            fault_next = head.abandon ? scpf_pkg::FAULT_ABANDON : scpf_pkg::FAULT_NONE;
            step_next  = ST_SYNC2;
          end
          scpf_pkg::KIND_DATA: begin
            byte_next = head.data;
            crc_next  = scpf_pkg::crc_feed(crc, head.data);
            if (head.last) begin
              step_next = ST_CRC_LO;
            end else begin
              fin = 1'b1;
            end
          end
          default: begin
            fault_next = scpf_pkg::FAULT_STRAY;
            valid_next = 1'b0;
            fin        = 1'b1;
          end
        endcase
      end
      ST_SYNC2: begin
        byte_next = sync_second;
        step_next = ST_ID;
      end
      ST_ID: begin
        byte_next = head.data;
        crc_next  = scpf_pkg::crc_feed(scpf_pkg::CRC_INIT, head.data);
        step_next = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        byte_next = head.len[7:0];
        crc_next  = scpf_pkg::crc_feed(crc, head.len[7:0]);
        step_next = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        byte_next = head.len[15:8];
        crc_next  = scpf_pkg::crc_feed(crc, head.len[15:8]);
        if (head.last) begin
          step_next = ST_CRC_LO;
        end else begin
          fin = 1'b1;
        end
      end
      ST_CRC_LO: begin
        byte_next = crc[7:0];
        step_next = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        byte_next = crc[15:8];
        fin       = 1'b1;
      end
      default: begin
        fin = 1'b1;
      end
    endcase
    if (fin) begin
      step_next = ST_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= ST_FIRST;
      crc         <= scpf_pkg::CRC_INIT;
      m_tvalid    <= 1'b0;
      m_tdata     <= '0;
      m_tuser     <= '0;
      m_tlast     <= 1'b0;
      sync_first  <= scpf_pkg::SYNC_FIRST_RESET;
      sync_second <= scpf_pkg::SYNC_SECOND_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          scpf_pkg::CFG_SYNC_FIRST:  sync_first  <= cfg_data;
          scpf_pkg::CFG_SYNC_SECOND: sync_second <= cfg_data;
          default: ;
        endcase
      end
      if (fire) begin
        step     <= step_next;
        crc      <= crc_next;
        m_tvalid <= 1'b1;
        m_tdata  <= byte_next;
        m_tuser  <= {valid_next, fault_next};
        m_tlast  <= fin;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/sync_crc_packet_framer.sv -----
// ----------------------------------------------------------------------------
// sync_crc_packet_framer
// Frames packets into a byte stream: sync bytes, id, length, payload and
// CRC-16/CCITT-FALSE over id, length and payload, low byte first.
//
//   channel  direction  contents
//   s_*      in         tuser: op; tdata: packet_id, payload_length, payload_byte
//   m_*      out        tdata: out_byte; tlast: frame_end; tuser: fault, byte_valid
//   cfg_*    in         cfg_index 0 sync_first, 1 sync_second
//
// One output byte per cycle from the back sequencer while the output is not
// stalled. Input words are taken one per cycle while the command queue has
// room (QUEUE_DEPTH entries). Reset is synchronous and needs no sweep. A
// stalled output holds the output register; the queue absorbs input.
// ----------------------------------------------------------------------------
module sync_crc_packet_framer #(
  parameter int QUEUE_DEPTH = scpf_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [scpf_pkg::S_DATA_W-1:0]     s_tdata,   // packet_id, payload_length, payload_byte
  input  logic [scpf_pkg::S_USER_W-1:0]     s_tuser,   // op
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [scpf_pkg::M_DATA_W-1:0]     m_tdata,   // out_byte
  output logic [scpf_pkg::M_USER_W-1:0]     m_tuser,   // fault, byte_valid
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic [scpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scpf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic           q_full;
  logic           q_push;
  scpf_pkg::cmd_t q_cmd;
  logic           q_pop;
  logic           q_head_valid;
  scpf_pkg::cmd_t q_head;

  scpf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  scpf_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  scpf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

// ----- src/scpf_checker.sv -----
// ----------------------------------------------------------------------------
// scpf_checker
// Port-level checks on the framed output stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "sync_crc_packet_framer_assert.svh"

module scpf_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [scpf_pkg::M_DATA_W-1:0]     m_tdata,
  input logic [scpf_pkg::M_USER_W-1:0]     m_tuser,
  input logic                              m_tlast
);

  `SCPF_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled output word changed")

  `SCPF_ASSERT_NOW(a_stray_shape, m_tvalid && !m_tuser[2], m_tuser[1:0] == scpf_pkg::FAULT_STRAY && m_tlast && m_tdata == '0, "fault-only word malformed")

  `SCPF_ASSERT_NOW(a_stray_no_byte, m_tvalid && m_tuser[1:0] == scpf_pkg::FAULT_STRAY, !m_tuser[2], "stray fault on a stream byte")

  `SCPF_ASSERT_NOW(a_abandon_open, m_tvalid && m_tuser[1:0] == scpf_pkg::FAULT_ABANDON, m_tuser[2] && !m_tlast, "abandon fault not on a header byte")

endmodule

bind sync_crc_packet_framer scpf_checker u_scpf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ----- bench/tb_sync_crc_packet_framer.sv -----
// ----------------------------------------------------------------------------
// tb_sync_crc_packet_framer
// Self-checking bench for the packet framer. Start and payload words are
// queued by the stimulus block and driven with random gaps. The output
// stream is taken with random stalls. Each accepted input word runs through
// a local framing model: sync bytes, header, payload pass-through and the
// CRC-16/CCITT-FALSE trailer. That model produces the expected output
// words, and each output word is checked field by field in order. Sync
// registers change between phases, only while the framer is idle.
// ----------------------------------------------------------------------------
module tb_sync_crc_packet_framer;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic        op;
    logic [7:0]  id;
    logic [15:0] len;
    logic [7:0]  pbyte;
  } word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] fault;
    logic       valid;
  } stream_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [scpf_pkg::S_DATA_W-1:0]   s_tdata = '0;
  logic [scpf_pkg::S_USER_W-1:0]   s_tuser = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [scpf_pkg::M_DATA_W-1:0]   m_tdata;
  logic [scpf_pkg::M_USER_W-1:0]   m_tuser;
  logic                            m_tlast;
  logic                            cfg_we = 1'b0;
  logic [scpf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [scpf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  word_t        pending_words[$];
  stream_byte_t expected_bytes[$];
  word_t        in_flight;
  int unsigned  src_gap = 0;
  int unsigned  sink_gap = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  errors = 0;
  bit           calm_src = 1'b1;
  bit           calm_sink = 1'b1;

  // framing model state
  logic [7:0]  sync_a = scpf_pkg::SYNC_FIRST_RESET;
  logic [7:0]  sync_b = scpf_pkg::SYNC_SECOND_RESET;
  logic [15:0] crc_run = scpf_pkg::CRC_INIT;
  logic [15:0] bytes_due = '0;
  logic        pkt_open = 1'b0;

  always #4 clk = ~clk;

  sync_crc_packet_framer DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // packet_id, payload_length, payload_byte
    .s_tuser   (s_tuser),    // op
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // out_byte
    .m_tuser   (m_tuser),    // fault, byte_valid
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic logic [15:0] crc_ccitt_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (acc[15]) begin
        acc = {acc[14:0], 1'b0} ^ 16'h1021;
      end else begin
        acc = {acc[14:0], 1'b0};
      end
    end
    return acc;
  endfunction

  function automatic int unsigned draw_gap(bit calm);
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic stream_byte_t sb(logic [7:0] d, logic [1:0] f, logic v);
    stream_byte_t s;
    s.data = d;
    s.last = 1'b0;
    s.fault = f;
    s.valid = v;
    return s;
  endfunction

  task automatic frame_word(word_t w);
    stream_byte_t outs[$];
    if (w.op == scpf_pkg::OP_START) begin
      outs.push_back(sb(sync_a, pkt_open ? scpf_pkg::FAULT_ABANDON : scpf_pkg::FAULT_NONE,
                        1'b1));
      outs.push_back(sb(sync_b, scpf_pkg::FAULT_NONE, 1'b1));
      outs.push_back(sb(w.id, scpf_pkg::FAULT_NONE, 1'b1));
      outs.push_back(sb(w.len[7:0], scpf_pkg::FAULT_NONE, 1'b1));
      outs.push_back(sb(w.len[15:8], scpf_pkg::FAULT_NONE, 1'b1));
      crc_run = crc_ccitt_step(scpf_pkg::CRC_INIT, w.id);
      crc_run = crc_ccitt_step(crc_run, w.len[7:0]);
      crc_run = crc_ccitt_step(crc_run, w.len[15:8]);
      bytes_due = w.len;
      pkt_open = 1'b1;
    end else if (!pkt_open) begin
      outs.push_back(sb(8'h00, scpf_pkg::FAULT_STRAY, 1'b0));
    end else begin
      outs.push_back(sb(w.pbyte, scpf_pkg::FAULT_NONE, 1'b1));
      crc_run = crc_ccitt_step(crc_run, w.pbyte);
      bytes_due = bytes_due - 16'd1;
    end
    if (pkt_open && bytes_due == 16'd0) begin
      outs.push_back(sb(crc_run[7:0], scpf_pkg::FAULT_NONE, 1'b1));
      outs.push_back(sb(crc_run[15:8], scpf_pkg::FAULT_NONE, 1'b1));
      pkt_open = 1'b0;
    end
    outs[outs.size()-1].last = 1'b1;
    foreach (outs[i]) expected_bytes.push_back(outs[i]);
  endtask

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) frame_word(in_flight);
      if (!(s_tvalid && !s_tready)) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_flight = pending_words.pop_front();
          s_tdata <= {in_flight.pbyte, in_flight.len, in_flight.id};
          s_tuser <= in_flight.op;
          s_tvalid <= 1'b1;
          src_gap <= draw_gap(calm_src);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    stream_byte_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          report("unexpected word", 16'(m_tdata), 16'h0);
        end else begin
          want = expected_bytes.pop_front();
          if (m_tdata !== want.data) report("out_byte", 16'(m_tdata), 16'(want.data));
          if (m_tlast !== want.last) report("frame_end", 16'(m_tlast), 16'(want.last));
          if (m_tuser[1:0] !== want.fault) begin
            report("fault", 16'(m_tuser[1:0]), 16'(want.fault));
          end
          if (m_tuser[2] !== want.valid) begin
            report("byte_valid", 16'(m_tuser[2]), 16'(want.valid));
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        sink_gap <= draw_gap(calm_sink);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic word_t start_word(logic [7:0] id, logic [15:0] len);
    word_t w;
    w.op = scpf_pkg::OP_START;
    w.id = id;
    w.len = len;
    w.pbyte = 8'($urandom_range(255));
    return w;
  endfunction

  function automatic word_t payload_word(logic [7:0] b);
    word_t w;
    w.op = scpf_pkg::OP_PAYLOAD;
    w.id = 8'($urandom_range(255));
    w.len = 16'($urandom_range(65535));
    w.pbyte = b;
    return w;
  endfunction

  task automatic write_reg(logic [scpf_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == scpf_pkg::CFG_SYNC_FIRST) sync_a = val;
    else sync_b = val;
  endtask

  task automatic wait_idle();
    while (pending_words.size() > 0 || s_tvalid || expected_bytes.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_burst(int unsigned n);
    int unsigned sent;
    int unsigned r;
    int unsigned len;
    int unsigned cut;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 12) begin
        // drop: stray byte, or filler for an open packet
        pending_words.push_back(payload_word(8'($urandom_range(255))));
        sent++;
      end else if (r < 22) begin
        // abandon: open a packet and leave it unfinished
        len = (r < 17) ? $urandom_range(65535, 1) : $urandom_range(8, 2);
        cut = $urandom_range((len > 6 ? 6 : len) - 1);
        pending_words.push_back(start_word(8'($urandom_range(255)), 16'(len)));
        repeat (cut) pending_words.push_back(payload_word(8'($urandom_range(255))));
        sent += cut + 1;
      end else begin
        len = ($urandom_range(99) < 75) ? $urandom_range(4) : $urandom_range(14, 5);
        pending_words.push_back(start_word(8'($urandom_range(255)), 16'(len)));
        repeat (len) pending_words.push_back(payload_word(8'($urandom_range(255))));
        sent += len + 1;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: stray, zero length, extremes, abandonment
    calm_src = 1'b0;
    calm_sink = 1'b0;
    pending_words.push_back(payload_word(8'h00));
    pending_words.push_back(start_word(8'h00, 16'd0));
    pending_words.push_back(start_word(8'hFF, 16'd1));
    pending_words.push_back(payload_word(8'hFF));
    pending_words.push_back(start_word(8'h5A, 16'd2));
    pending_words.push_back(payload_word(8'h00));
    pending_words.push_back(payload_word(8'hA5));
    pending_words.push_back(start_word(8'h12, 16'hFFFF));
    pending_words.push_back(payload_word(8'h3C));
    pending_words.push_back(start_word(8'hAB, 16'd3));
    pending_words.push_back(payload_word(8'h01));
    pending_words.push_back(payload_word(8'h80));
    pending_words.push_back(payload_word(8'h7F));
    pending_words.push_back(payload_word(8'hFF));
    pending_words.push_back(start_word(8'h81, 16'h8000));
    pending_words.push_back(start_word(8'h7E, 16'd0));
    pending_words.push_back(start_word(8'hC3, 16'h0100));
    pending_words.push_back(start_word(8'h3C, 16'h00FF));
    pending_words.push_back(start_word(8'h00, 16'd0));
    wait_idle();

    write_reg(scpf_pkg::CFG_SYNC_FIRST, 8'h00);
    write_reg(scpf_pkg::CFG_SYNC_SECOND, 8'hFF);
    calm_src = 1'b1;
    random_burst(50);
    wait_idle();

    write_reg(scpf_pkg::CFG_SYNC_FIRST, 8'($urandom_range(255)));
    write_reg(scpf_pkg::CFG_SYNC_SECOND, 8'($urandom_range(255)));
    calm_src = 1'b0;
    random_burst(50);
    wait_idle();

    write_reg(scpf_pkg::CFG_SYNC_FIRST, 8'hFF);
    write_reg(scpf_pkg::CFG_SYNC_SECOND, 8'h00);
    calm_sink = 1'b1;
    random_burst(50);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_bytes.size() > 0) begin
      report("missing words", 16'(expected_bytes.size()), 16'h0);
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
